// ----- rtl/spq_pkg.sv -----
// Package for the stable priority queue: sizes, operation and status codes,
// and the packed transaction types of both channels. No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH         = 16;
    localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W       = $clog2(DEPTH + 1);
    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 5;
    localparam int STATUS_W      = 2;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                       cmd;
        logic signed [VALUE_W-1:0]  item_value;
        logic signed [VALUE_W-1:0]  item_priority;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  head_value;
        logic signed [VALUE_W-1:0]  head_priority;
        logic [ENTRY_COUNT_W-1:0]   entry_count;
        logic                       queue_empty;
        logic [STATUS_W-1:0]        status;
    } t_out_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  value;
        logic signed [VALUE_W-1:0]  prio;
    } t_entry;

endpackage

// ----- rtl/stable_priority_queue.sv -----
// Stable priority queue: entries in a circular buffer held in one synchronous
// memory, kept sorted by insertion from the tail. Depends on spq_pkg.
// Sequence: a rejected transaction, a dequeue that empties the queue and an enqueue
// into an empty queue go straight to the done state; a dequeue that exposes a new
// head reads it in the dequeue state, and any other enqueue moves one stored entry
// towards the tail per scan step. The done state registers the result and raises
// o_out_valid, waiting while the output is stalled. Handshake: one transaction at
// a time; the next is accepted the cycle after the result is registered.
// Reset: the queue comes out of reset empty; the entry memory is not cleared.
`timescale 1ns / 1ps

module stable_priority_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  spq_pkg::t_in_item  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output spq_pkg::t_out_item o_out_data
);

    localparam int AW = spq_pkg::ADDR_W;
    localparam int CW = spq_pkg::COUNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DEQ  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] a);
        f_next = (a == AW'(spq_pkg::DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] a);
        f_prev = (a == '0) ? AW'(spq_pkg::DEPTH - 1) : a - AW'(1);
    endfunction

    spq_pkg::t_entry r_mem [spq_pkg::DEPTH];
    spq_pkg::t_entry r_rd_data;

    logic [1:0]                   r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [AW-1:0]                r_head_ptr, n_head_ptr;
    logic [AW-1:0]                r_tail_ptr, n_tail_ptr;
    logic [AW-1:0]                r_wr_slot, n_wr_slot;
    logic [AW-1:0]                r_left, n_left;
    spq_pkg::t_entry              r_new, n_new;
    spq_pkg::t_entry              r_head, n_head;
    logic [spq_pkg::STATUS_W-1:0] r_status, n_status;
    logic                         r_out_valid, n_out_valid;
    spq_pkg::t_out_item           r_out, n_out;

    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    spq_pkg::t_entry              wr_data;
    logic                         accept;
    spq_pkg::t_entry              in_entry;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_entry   = '{value: i_in_data.item_value, prio: i_in_data.item_priority};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head_ptr  = r_head_ptr;
        n_tail_ptr  = r_tail_ptr;
        n_wr_slot   = r_wr_slot;
        n_left      = r_left;
        n_new       = r_new;
        n_head      = r_head;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = f_prev(r_tail_ptr);
        wr_en       = 1'b0;
        wr_addr     = r_wr_slot;
        wr_data     = r_new;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_status = spq_pkg::STATUS_OK;
                    n_state  = ST_DONE;
                    if (i_in_data.cmd == spq_pkg::CMD_ENQUEUE) begin
                        if (r_count == CW'(spq_pkg::DEPTH)) begin
                            n_status = spq_pkg::STATUS_FULL;
                        end else begin
                            n_new      = in_entry;
                            n_count    = r_count + CW'(1);
                            n_tail_ptr = f_next(r_tail_ptr);
                            n_wr_slot  = r_tail_ptr;
                            n_left     = AW'(r_count);
                            if (r_count == '0 || in_entry.prio > r_head.prio) begin
                                n_head = in_entry;
                            end
                            if (r_count == '0) begin
                                wr_en   = 1'b1;
                                wr_addr = r_tail_ptr;
                                wr_data = in_entry;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = f_prev(r_tail_ptr);
                                n_state = ST_SCAN;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = spq_pkg::STATUS_EMPTY;
                        end else begin
                            n_count    = r_count - CW'(1);
                            n_head_ptr = f_next(r_head_ptr);
                            if (r_count != CW'(1)) begin
                                rd_en   = 1'b1;
                                rd_addr = f_next(r_head_ptr);
                                n_state = ST_DEQ;
                            end
                        end
                    end
                end
            end
            ST_SCAN: begin
                wr_en = 1'b1;
                if (r_left == '0 || r_rd_data.prio >= r_new.prio) begin
                    wr_data = r_new;
                    n_state = ST_DONE;
                end else begin
                    wr_data   = r_rd_data;
                    n_wr_slot = f_prev(r_wr_slot);
                    n_left    = r_left - AW'(1);
                    rd_en     = 1'b1;
                    rd_addr   = f_prev(f_prev(r_wr_slot));
                end
            end
            ST_DEQ: begin
                n_head  = r_rd_data;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.head_value    = (r_count == '0) ? '0 : r_head.value;
                    n_out.head_priority = (r_count == '0) ? '0 : r_head.prio;
                    n_out.entry_count   = spq_pkg::ENTRY_COUNT_W'(r_count);
                    n_out.queue_empty   = (r_count == '0);
                    n_out.status        = r_status;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_head_ptr  <= '0;
            r_tail_ptr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head_ptr  <= n_head_ptr;
            r_tail_ptr  <= n_tail_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_slot <= n_wr_slot;
        r_left    <= n_left;
        r_new     <= n_new;
        r_head    <= n_head;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
